>>> hw/rtl/cfa_instruction_encoder_defines.svh
// Assertion macros used by the call frame instruction encoder checker.
`ifndef CFA_INSTRUCTION_ENCODER_DEFINES_SVH
`define CFA_INSTRUCTION_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cfa_enc_pkg.sv
// Types, constants and the instruction decode table of the call frame instruction encoder.
`timescale 1ns / 1ps
`default_nettype none

package cfa_enc_pkg;

  // Register numbers are coded after dropping bits above this width.
  localparam int unsigned REGISTER_BITS = 16;
  localparam logic [15:0] REG_MASK =
      (REGISTER_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << REGISTER_BITS) - 32'd1);

  typedef enum logic [4:0] {
    MODE_NOP              = 5'd0,
    MODE_SET_LOC          = 5'd1,
    MODE_ADVANCE_LOC      = 5'd2,
    MODE_ADVANCE_LOC1     = 5'd3,
    MODE_ADVANCE_LOC2     = 5'd4,
    MODE_ADVANCE_LOC4     = 5'd5,
    MODE_DEF_CFA          = 5'd6,
    MODE_DEF_CFA_SF       = 5'd7,
    MODE_DEF_CFA_REGISTER = 5'd8,
    MODE_DEF_CFA_OFFSET   = 5'd9,
    MODE_DEF_CFA_OFFSET_SF = 5'd10,
    MODE_UNDEFINED        = 5'd11,
    MODE_SAME_VALUE       = 5'd12,
    MODE_OFFSET           = 5'd13,
    MODE_OFFSET_EXT       = 5'd14,
    MODE_OFFSET_EXT_SF    = 5'd15,
    MODE_VAL_OFFSET       = 5'd16,
    MODE_VAL_OFFSET_SF    = 5'd17,
    MODE_REGISTER         = 5'd18,
    MODE_RESTORE          = 5'd19,
    MODE_RESTORE_EXT      = 5'd20,
    MODE_REMEMBER_STATE   = 5'd21,
    MODE_RESTORE_STATE    = 5'd22
  } mode_e;

  // Opcode bytes, with the operand bits clear for the compact forms.
  localparam logic [7:0] OPC_NOP              = 8'h00;
  localparam logic [7:0] OPC_SET_LOC          = 8'h01;
  localparam logic [7:0] OPC_ADVANCE_LOC1     = 8'h02;
  localparam logic [7:0] OPC_ADVANCE_LOC2     = 8'h03;
  localparam logic [7:0] OPC_ADVANCE_LOC4     = 8'h04;
  localparam logic [7:0] OPC_OFFSET_EXT       = 8'h05;
  localparam logic [7:0] OPC_RESTORE_EXT      = 8'h06;
  localparam logic [7:0] OPC_UNDEFINED        = 8'h07;
  localparam logic [7:0] OPC_SAME_VALUE       = 8'h08;
  localparam logic [7:0] OPC_REGISTER         = 8'h09;
  localparam logic [7:0] OPC_REMEMBER_STATE   = 8'h0A;
  localparam logic [7:0] OPC_RESTORE_STATE    = 8'h0B;
  localparam logic [7:0] OPC_DEF_CFA          = 8'h0C;
  localparam logic [7:0] OPC_DEF_CFA_REGISTER = 8'h0D;
  localparam logic [7:0] OPC_DEF_CFA_OFFSET   = 8'h0E;
  localparam logic [7:0] OPC_OFFSET_EXT_SF    = 8'h11;
  localparam logic [7:0] OPC_DEF_CFA_SF       = 8'h12;
  localparam logic [7:0] OPC_DEF_CFA_OFFSET_SF = 8'h13;
  localparam logic [7:0] OPC_VAL_OFFSET       = 8'h14;
  localparam logic [7:0] OPC_VAL_OFFSET_SF    = 8'h15;
  localparam logic [7:0] OPC_ADVANCE_LOC      = 8'h40;
  localparam logic [7:0] OPC_OFFSET           = 8'h80;
  localparam logic [7:0] OPC_RESTORE          = 8'hC0;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FIX,
    KIND_ULEB,
    KIND_SLEB
  } kind_e;

  typedef enum logic [1:0] {
    SRC_LOC,
    SRC_R1,
    SRC_UOFF,
    SRC_SOFF_R2
  } src_e;

  typedef enum logic [1:0] {
    LOW_NONE,
    LOW_LOC,
    LOW_R1
  } low_e;

  typedef struct packed {
    logic        valid;
    logic [7:0]  opc;
    low_e        low_src;
    kind_e       kind_a;
    src_e        src_a;
    logic [3:0]  fix_len;
    kind_e       kind_b;
    src_e        src_b;
  } cfa_enc_plan_t;

  typedef struct packed {
    logic [4:0]         mode;
    logic [15:0]        reg_first;
    logic [15:0]        reg_second;
    logic [63:0]        location_or_delta;
    logic [63:0]        offset_unsigned;
    logic signed [63:0] offset_signed;
  } cfa_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } cfa_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic          load;
    logic          emit;
    logic          use_opc;
    kind_e         kind;
    logic          reload_b;
    logic          last;
    cfa_enc_plan_t plan;
  } cfa_enc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic can_emit;
    logic shift_last;
  } cfa_enc_sts_t;

  // Operand A: loc for fixed forms, r1 or an offset for LEB forms.
  // Operand B: SRC_SOFF_R2 picks soff for SLEB and r2 for ULEB.
  function automatic cfa_enc_plan_t cfa_decode(logic [4:0] mode);
    cfa_enc_plan_t p;
    p = '{valid: 1'b1, opc: OPC_NOP, low_src: LOW_NONE, kind_a: KIND_NONE,
          src_a: SRC_R1, fix_len: 4'd0, kind_b: KIND_NONE, src_b: SRC_UOFF};
    case (mode)
      MODE_NOP: p.opc = OPC_NOP;
      MODE_SET_LOC: begin
        p.opc = OPC_SET_LOC; p.kind_a = KIND_FIX; p.src_a = SRC_LOC; p.fix_len = 4'd8;
      end
      MODE_ADVANCE_LOC: begin
        p.opc = OPC_ADVANCE_LOC; p.low_src = LOW_LOC;
      end
      MODE_ADVANCE_LOC1: begin
        p.opc = OPC_ADVANCE_LOC1; p.kind_a = KIND_FIX; p.src_a = SRC_LOC; p.fix_len = 4'd1;
      end
      MODE_ADVANCE_LOC2: begin
        p.opc = OPC_ADVANCE_LOC2; p.kind_a = KIND_FIX; p.src_a = SRC_LOC; p.fix_len = 4'd2;
      end
      MODE_ADVANCE_LOC4: begin
        p.opc = OPC_ADVANCE_LOC4; p.kind_a = KIND_FIX; p.src_a = SRC_LOC; p.fix_len = 4'd4;
      end
      MODE_DEF_CFA: begin
        p.opc = OPC_DEF_CFA; p.kind_a = KIND_ULEB; p.kind_b = KIND_ULEB; p.src_b = SRC_UOFF;
      end
      MODE_DEF_CFA_SF: begin
        p.opc = OPC_DEF_CFA_SF; p.kind_a = KIND_ULEB;
        p.kind_b = KIND_SLEB; p.src_b = SRC_SOFF_R2;
      end
      MODE_DEF_CFA_REGISTER: begin
        p.opc = OPC_DEF_CFA_REGISTER; p.kind_a = KIND_ULEB;
      end
      MODE_DEF_CFA_OFFSET: begin
        p.opc = OPC_DEF_CFA_OFFSET; p.kind_a = KIND_ULEB; p.src_a = SRC_UOFF;
      end
      MODE_DEF_CFA_OFFSET_SF: begin
        p.opc = OPC_DEF_CFA_OFFSET_SF; p.kind_a = KIND_SLEB; p.src_a = SRC_SOFF_R2;
      end
      MODE_UNDEFINED: begin
        p.opc = OPC_UNDEFINED; p.kind_a = KIND_ULEB;
      end
      MODE_SAME_VALUE: begin
        p.opc = OPC_SAME_VALUE; p.kind_a = KIND_ULEB;
      end
      MODE_OFFSET: begin
        p.opc = OPC_OFFSET; p.low_src = LOW_R1; p.kind_a = KIND_ULEB; p.src_a = SRC_UOFF;
      end
      MODE_OFFSET_EXT: begin
        p.opc = OPC_OFFSET_EXT; p.kind_a = KIND_ULEB; p.kind_b = KIND_ULEB; p.src_b = SRC_UOFF;
      end
      MODE_OFFSET_EXT_SF: begin
        p.opc = OPC_OFFSET_EXT_SF; p.kind_a = KIND_ULEB;
        p.kind_b = KIND_SLEB; p.src_b = SRC_SOFF_R2;
      end
      MODE_VAL_OFFSET: begin
        p.opc = OPC_VAL_OFFSET; p.kind_a = KIND_ULEB; p.kind_b = KIND_ULEB; p.src_b = SRC_UOFF;
      end
      MODE_VAL_OFFSET_SF: begin
        p.opc = OPC_VAL_OFFSET_SF; p.kind_a = KIND_ULEB;
        p.kind_b = KIND_SLEB; p.src_b = SRC_SOFF_R2;
      end
      MODE_REGISTER: begin
        p.opc = OPC_REGISTER; p.kind_a = KIND_ULEB;
        p.kind_b = KIND_ULEB; p.src_b = SRC_SOFF_R2;
      end
      MODE_RESTORE: begin
        p.opc = OPC_RESTORE; p.low_src = LOW_R1;
      end
      MODE_RESTORE_EXT: begin
        p.opc = OPC_RESTORE_EXT; p.kind_a = KIND_ULEB;
      end
      MODE_REMEMBER_STATE: p.opc = OPC_REMEMBER_STATE;
      MODE_RESTORE_STATE:  p.opc = OPC_RESTORE_STATE;
      default: p.valid = 1'b0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cfa_enc_ctrl.sv
// Sequencer: walks opcode, first operand and second operand of one instruction.
`timescale 1ns / 1ps
`default_nettype none

module cfa_enc_ctrl import cfa_enc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic [4:0]   mode_i,
  output logic         in_ready_o,
  input  cfa_enc_sts_t sts_i,
  output cfa_enc_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OPC,
    ST_OPA,
    ST_OPB
  } state_e;

  state_e        state_q, state_d;
  cfa_enc_plan_t plan_q, plan_d;
  cfa_enc_plan_t dec;
  logic          accept;

  assign dec        = cfa_decode(mode_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d          = state_q;
    plan_d           = plan_q;
    cmd_o            = '0;
    cmd_o.load       = accept;
    cmd_o.plan       = accept ? dec : plan_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          plan_d = dec;
          // drop undefined modes: no bytes
          if (dec.valid) state_d = ST_OPC;
        end
      end
      ST_OPC: begin
        if (sts_i.can_emit) begin
          cmd_o.emit    = 1'b1;
          cmd_o.use_opc = 1'b1;
          cmd_o.last    = (plan_q.kind_a == KIND_NONE);
          state_d       = cmd_o.last ? ST_IDLE : ST_OPA;
        end
      end
      ST_OPA: begin
        cmd_o.kind = plan_q.kind_a;
        if (sts_i.can_emit) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = sts_i.shift_last && (plan_q.kind_b == KIND_NONE);
          if (sts_i.shift_last) begin
            if (plan_q.kind_b == KIND_NONE) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.reload_b = 1'b1;
              state_d        = ST_OPB;
            end
          end
        end
      end
      ST_OPB: begin
        cmd_o.kind = plan_q.kind_b;
        if (sts_i.can_emit) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = sts_i.shift_last;
          if (sts_i.shift_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      plan_q  <= '0;
    end else begin
      state_q <= state_d;
      plan_q  <= plan_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cfa_enc_dp.sv
// Datapath: operand store, byte shifter with LEB128 and fixed coding, output register.
`timescale 1ns / 1ps
`default_nettype none

module cfa_enc_dp import cfa_enc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfa_in_t      in_data_i,
  input  cfa_enc_cmd_t cmd_i,
  output cfa_enc_sts_t sts_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output cfa_out_t     out_data_o
);

  logic [63:0] uoff_q, soff_q;
  logic [15:0] r2_q;
  logic [7:0]  opc_q, opc_d;
  logic [63:0] val_q, val_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  cfa_out_t    out_data_q, out_data_d;

  logic [63:0] uleb_nxt, sleb_nxt, nxt, a_val, b_val;
  logic [7:0]  sh_byte;
  logic        sh_last;
  logic [5:0]  low6;

  assign uleb_nxt = {7'd0, val_q[63:7]};
  assign sleb_nxt = {{7{val_q[63]}}, val_q[63:7]};

  always_comb begin
    case (cmd_i.kind)
      KIND_FIX: begin
        sh_last = (cnt_q == 4'd1);
        sh_byte = val_q[7:0];
        nxt     = {8'd0, val_q[63:8]};
      end
      KIND_ULEB: begin
        sh_last = (uleb_nxt == '0);
        sh_byte = {~sh_last, val_q[6:0]};
        nxt     = uleb_nxt;
      end
      KIND_SLEB: begin
        sh_last = ((sleb_nxt == '0) && !val_q[6]) || ((sleb_nxt == '1) && val_q[6]);
        sh_byte = {~sh_last, val_q[6:0]};
        nxt     = sleb_nxt;
      end
      default: begin
        sh_last = 1'b1;
        sh_byte = val_q[7:0];
        nxt     = val_q;
      end
    endcase
  end

  assign sts_o.shift_last = sh_last;
  assign sts_o.can_emit   = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.plan.src_a)
      SRC_LOC:     a_val = in_data_i.location_or_delta;
      SRC_R1:      a_val = {48'd0, in_data_i.reg_first & REG_MASK};
      SRC_UOFF:    a_val = in_data_i.offset_unsigned;
      default:     a_val = in_data_i.offset_signed;
    endcase
    case (cmd_i.plan.src_b)
      SRC_UOFF:    b_val = uoff_q;
      SRC_SOFF_R2: b_val = (cmd_i.plan.kind_b == KIND_SLEB) ? soff_q : {48'd0, r2_q & REG_MASK};
      default:     b_val = uoff_q;
    endcase
    case (cmd_i.plan.low_src)
      LOW_LOC: low6 = in_data_i.location_or_delta[5:0];
      LOW_R1:  low6 = in_data_i.reg_first[5:0];
      default: low6 = 6'd0;
    endcase
  end

  always_comb begin
    val_d       = val_q;
    cnt_d       = cnt_q;
    opc_d       = opc_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      val_d = a_val;
      cnt_d = cmd_i.plan.fix_len;
      opc_d = cmd_i.plan.opc | {2'b00, low6};
    end else if (cmd_i.reload_b) begin
      val_d = b_val;
    end else if (cmd_i.emit && !cmd_i.use_opc) begin
      val_d = nxt;
      cnt_d = cnt_q - 4'd1;
    end
    if (cmd_i.emit) begin
      out_valid_d           = 1'b1;
      out_data_d.out_byte   = cmd_i.use_opc ? opc_q : sh_byte;
      out_data_d.last_byte  = cmd_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      uoff_q <= in_data_i.offset_unsigned;
      soff_q <= in_data_i.offset_signed;
      r2_q   <= in_data_i.reg_second;
    end
    val_q      <= val_d;
    cnt_q      <= cnt_d;
    opc_q      <= opc_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> hw/rtl/cfa_instruction_encoder.sv
// Top level of the call frame instruction encoder: sequencer plus datapath.
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one call frame
//   instruction per beat: mode selects one of 23 instruction kinds, the other
//   fields carry register numbers, a location or delta, and the offsets.
//   Output channel (out_valid_o/out_ready_i/out_data_o) gives the encoded
//   instruction one byte per beat, with last_byte set on its final byte.
//   An instruction of 1 to 14 bytes occupies the sequencer from the accepting
//   edge until its last byte is registered; the sequencer then returns to
//   idle to take the next beat, so no new instruction is taken mid-way.
//   The single byte shifter emits one byte per cycle unless output stalls.
//   The opcode byte is registered as soon as the output register can take it.
//   Undefined modes (23 to 31) are taken and dropped without any bytes.
//   A one-deep output register parts the two sides: the next instruction is
//   accepted while the last byte of the previous one still waits.
//   When the receiver stalls, hold the pending byte and stop the shifter;
//   in_ready_o stays low until the instruction's bytes are all registered.
//   Reset (rst_ni low, asynchronous) returns the sequencer to idle and
//   empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module cfa_instruction_encoder import cfa_enc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cfa_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cfa_out_t out_data_o
);

  cfa_enc_cmd_t cmd;
  cfa_enc_sts_t sts;

  // Sequencer: decodes mode at the accepting beat and steps through operands.
  cfa_enc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (in_data_i.mode),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: captures operands, shifts out bytes, holds the output beat.
  cfa_enc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/cfa_enc_chk.sv
// Port-level checker for the call frame instruction encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "cfa_instruction_encoder_defines.svh"

module cfa_enc_chk import cfa_enc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input cfa_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input cfa_out_t out_data_o
);

  logic [3:0] beat_cnt_q;
  logic       out_beat;

  assign out_beat = out_valid_o && out_ready_i;

  // Count bytes of the current instruction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_cnt_q <= 4'd0;
    end else if (out_beat) begin
      beat_cnt_q <= out_data_o.last_byte ? 4'd0 : beat_cnt_q + 4'd1;
    end
  end

  `CFA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o), "output beat changed while stalled")

  `CFA_ASSERT_IMP(a_max_len, clk_i, rst_ni, out_beat,
    beat_cnt_q <= 4'd13, "instruction longer than 14 bytes")

  `CFA_ASSERT_IMP(a_busy_mid, clk_i, rst_ni, out_valid_o && !out_data_o.last_byte,
    !in_ready_o, "input ready while an instruction is unfinished")

  `CFA_ASSERT_IMP(a_nop_byte, clk_i, rst_ni,
    in_valid_i && in_ready_o && !out_valid_o && (in_data_i.mode == MODE_NOP),
    ##2 (out_valid_o && (out_data_o.out_byte == OPC_NOP) && out_data_o.last_byte),
    "nop did not give a single zero byte")

endmodule

bind cfa_instruction_encoder cfa_enc_chk u_cfa_enc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> verif/tb_cfa_instruction_encoder.sv
// Self-checking testbench for the call frame instruction encoder.
`timescale 1ns / 1ps

module tb_cfa_instruction_encoder;
  import cfa_enc_pkg::*;

  // Modes past the last instruction kind; the block takes and drops them.
  localparam logic [4:0] MODE_FIRST_UNUSED = 5'd23;
  localparam logic [4:0] MODE_LAST_UNUSED  = 5'd31;

  // LEB128 continuation flag.
  localparam logic [7:0] LEB_MORE = 8'h80;

  localparam int unsigned RANDOM_INSTRS = 410;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 40;

  // How a directed row gets its expected bytes.
  typedef enum logic [1:0] {
    CHK_MODEL,     // from the predictor
    CHK_ONE_BYTE,  // one byte typed in the table, last set
    CHK_NONE       // ignored mode, no bytes
  } chk_e;

  typedef struct {
    cfa_in_t     item;
    chk_e        check;
    logic [7:0]  one_byte;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  cfa_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  cfa_out_t    out_data;

  // Hold both sides free of idle cycles while set.
  logic        steady_flow = 1'b0;

  cfa_out_t    expected_bytes[$];
  dir_row_t    directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  cfa_instruction_encoder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Byte predictor: append the bytes of one instruction to expected_bytes.
  // ---------------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] b);
    expected_bytes.push_back('{out_byte: b, last_byte: 1'b0});
  endfunction

  function automatic void push_fixed(input logic [63:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      push_byte(v[7:0]);
      v = v >> 8;
    end
  endfunction

  function automatic void push_uleb(input logic [63:0] v);
    logic [7:0] group;
    forever begin
      group = {1'b0, v[6:0]};
      v = v >> 7;
      if (v == '0) begin
        push_byte(group);
        return;
      end
      push_byte(LEB_MORE | group);
    end
  endfunction

  // Stop once the remaining bits are all copies of the group's sign bit.
  function automatic void push_sleb(input logic signed [63:0] v);
    logic [7:0] group;
    forever begin
      group = {1'b0, v[6:0]};
      v = v >>> 7;
      if ((v == '0 && !group[6]) || (v == '1 && group[6])) begin
        push_byte(group);
        return;
      end
      push_byte(LEB_MORE | group);
    end
  endfunction

  function automatic void encode_instr(input cfa_in_t it);
    int unsigned first;
    logic [63:0] r1;
    logic [63:0] r2;
    first = expected_bytes.size();
    r1 = 64'(it.reg_first & REG_MASK);
    r2 = 64'(it.reg_second & REG_MASK);
    case (it.mode)
      MODE_NOP:              push_byte(OPC_NOP);
      MODE_SET_LOC: begin
        push_byte(OPC_SET_LOC); push_fixed(it.location_or_delta, 8);
      end
      // Compact forms keep only the low six operand bits.
      MODE_ADVANCE_LOC:      push_byte(OPC_ADVANCE_LOC | {2'b00, it.location_or_delta[5:0]});
      MODE_ADVANCE_LOC1: begin
        push_byte(OPC_ADVANCE_LOC1); push_fixed(it.location_or_delta, 1);
      end
      MODE_ADVANCE_LOC2: begin
        push_byte(OPC_ADVANCE_LOC2); push_fixed(it.location_or_delta, 2);
      end
      MODE_ADVANCE_LOC4: begin
        push_byte(OPC_ADVANCE_LOC4); push_fixed(it.location_or_delta, 4);
      end
      MODE_DEF_CFA: begin
        push_byte(OPC_DEF_CFA); push_uleb(r1); push_uleb(it.offset_unsigned);
      end
      MODE_DEF_CFA_SF: begin
        push_byte(OPC_DEF_CFA_SF); push_uleb(r1); push_sleb(it.offset_signed);
      end
      MODE_DEF_CFA_REGISTER: begin
        push_byte(OPC_DEF_CFA_REGISTER); push_uleb(r1);
      end
      MODE_DEF_CFA_OFFSET: begin
        push_byte(OPC_DEF_CFA_OFFSET); push_uleb(it.offset_unsigned);
      end
      MODE_DEF_CFA_OFFSET_SF: begin
        push_byte(OPC_DEF_CFA_OFFSET_SF); push_sleb(it.offset_signed);
      end
      MODE_UNDEFINED: begin
        push_byte(OPC_UNDEFINED); push_uleb(r1);
      end
      MODE_SAME_VALUE: begin
        push_byte(OPC_SAME_VALUE); push_uleb(r1);
      end
      MODE_OFFSET: begin
        push_byte(OPC_OFFSET | {2'b00, it.reg_first[5:0]}); push_uleb(it.offset_unsigned);
      end
      MODE_OFFSET_EXT: begin
        push_byte(OPC_OFFSET_EXT); push_uleb(r1); push_uleb(it.offset_unsigned);
      end
      MODE_OFFSET_EXT_SF: begin
        push_byte(OPC_OFFSET_EXT_SF); push_uleb(r1); push_sleb(it.offset_signed);
      end
      MODE_VAL_OFFSET: begin
        push_byte(OPC_VAL_OFFSET); push_uleb(r1); push_uleb(it.offset_unsigned);
      end
      MODE_VAL_OFFSET_SF: begin
        push_byte(OPC_VAL_OFFSET_SF); push_uleb(r1); push_sleb(it.offset_signed);
      end
      MODE_REGISTER: begin
        push_byte(OPC_REGISTER); push_uleb(r1); push_uleb(r2);
      end
      MODE_RESTORE:          push_byte(OPC_RESTORE | {2'b00, it.reg_first[5:0]});
      MODE_RESTORE_EXT: begin
        push_byte(OPC_RESTORE_EXT); push_uleb(r1);
      end
      MODE_REMEMBER_STATE:   push_byte(OPC_REMEMBER_STATE);
      MODE_RESTORE_STATE:    push_byte(OPC_RESTORE_STATE);
      default: ;  // unused mode: dropped, no bytes
    endcase
    if (expected_bytes.size() > first)
      expected_bytes[expected_bytes.size() - 1].last_byte = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic dir_row_t row(input logic [4:0] mode, input logic [15:0] r1,
                                   input logic [15:0] r2, input logic [63:0] loc,
                                   input logic [63:0] uoff,
                                   input logic signed [63:0] soff,
                                   input chk_e check, input logic [7:0] one_byte);
    dir_row_t r;
    r.item = '{mode: mode, reg_first: r1, reg_second: r2, location_or_delta: loc,
               offset_unsigned: uoff, offset_signed: soff};
    r.check = check;
    r.one_byte = one_byte;
    return r;
  endfunction

  // Random value with only the low 'w' bits live, so LEB lengths spread out.
  function automatic logic [63:0] rand_bits(input int unsigned w);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (w < 64) v = v & ((64'd1 << w) - 64'd1);
    return v;
  endfunction

  function automatic cfa_in_t rand_instr();
    cfa_in_t     it;
    int unsigned w;
    // Keep most beats on real instruction kinds; a few unused modes as noise.
    if ($urandom_range(0, 99) < 5)
      it.mode = 5'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED));
    else
      it.mode = 5'($urandom_range(MODE_NOP, MODE_RESTORE_STATE));
    it.reg_first  = 16'(rand_bits($urandom_range(0, 16)));
    it.reg_second = 16'(rand_bits($urandom_range(0, 16)));
    it.location_or_delta = rand_bits($urandom_range(0, 64));
    it.offset_unsigned   = rand_bits($urandom_range(0, 64));
    // Sign-extend from a random width to get short negative values too.
    w = $urandom_range(1, 64);
    it.offset_signed = $signed(rand_bits(w) << (64 - w)) >>> (64 - w);
    return it;
  endfunction

  // Offer one instruction beat, idling first at random; return at the accepting edge.
  task automatic send_instr(input cfa_in_t it);
    while (!steady_flow && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, compare each beat with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cfa_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_data.out_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_data.out_byte, want.out_byte));
          if (out_data.last_byte !== want.last_byte)
            report_mismatch($sformatf("last_byte %0b, expected %0b on byte %02h",
                                      out_data.last_byte, want.last_byte, want.out_byte));
        end
      end
      out_ready <= steady_flow || ($urandom_range(0, 99) >= 20);
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfa_in_t     it;
    int unsigned random_sent;
    int unsigned drain;

    // Directed table: extremes of every field, every instruction kind, the
    // dropped compact bits, the register mask and the unused modes.
    directed_rows.push_back(row(MODE_NOP, 16'hFFFF, 16'hFFFF, '1, '1, -64'sd1,
                                CHK_ONE_BYTE, OPC_NOP));
    directed_rows.push_back(row(MODE_SET_LOC, 16'h0, 16'h0, '1, '0, '0, CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_ADVANCE_LOC, 16'h0, 16'h0, '0, '0, '0,
                                CHK_ONE_BYTE, OPC_ADVANCE_LOC));
    directed_rows.push_back(row(MODE_ADVANCE_LOC, 16'h0, 16'h0, '1, '0, '0,
                                CHK_ONE_BYTE, OPC_ADVANCE_LOC | 8'h3F));
    directed_rows.push_back(row(MODE_ADVANCE_LOC1, 16'h0, 16'h0, '1, '0, '0, CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_ADVANCE_LOC2, 16'h0, 16'h0, 64'hFFFF_0000_0000_A55A,
                                '0, '0, CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_ADVANCE_LOC4, 16'h0, 16'h0, '1, '0, '0, CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_DEF_CFA, 16'hFFFF, 16'h0, '0, '1, '0, CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_DEF_CFA_SF, 16'h0, 16'h0, '0, '0,
                                64'sh8000_0000_0000_0000, CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_DEF_CFA_SF, 16'h007F, 16'h0, '0, '0,
                                64'sh7FFF_FFFF_FFFF_FFFF, CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_DEF_CFA_REGISTER, 16'h0080, 16'h0, '0, '0, '0,
                                CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_DEF_CFA_OFFSET, 16'h0, 16'h0, '0, '0, '0,
                                CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_DEF_CFA_OFFSET_SF, 16'h0, 16'h0, '0, '0, 64'sd64,
                                CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_DEF_CFA_OFFSET_SF, 16'h0, 16'h0, '0, '0, -64'sd65,
                                CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_UNDEFINED, 16'hFFFF, 16'h0, '0, '0, '0, CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_SAME_VALUE, 16'h3FFF, 16'h0, '0, '0, '0,
                                CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_OFFSET, 16'hFFFF, 16'h0, '0, 64'h7F, '0, CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_OFFSET_EXT, 16'h1234, 16'h0, '0, 64'h80, '0,
                                CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_OFFSET_EXT_SF, 16'h0001, 16'h0, '0, '0, -64'sd129,
                                CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_VAL_OFFSET, 16'hFFFF, 16'h0, '0, '1, '0, CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_VAL_OFFSET_SF, 16'h0, 16'h0, '0, '0,
                                64'sh7FFF_FFFF_FFFF_FFFF, CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_REGISTER, 16'hFFFF, 16'hFFFF, '0, '0, '0,
                                CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_RESTORE, 16'hFFFF, 16'h0, '0, '0, '0,
                                CHK_ONE_BYTE, OPC_RESTORE | 8'h3F));
    directed_rows.push_back(row(MODE_RESTORE_EXT, 16'hFFFF, 16'h0, '0, '0, '0,
                                CHK_MODEL, '0));
    directed_rows.push_back(row(MODE_REMEMBER_STATE, 16'h0, 16'h0, '0, '0, '0,
                                CHK_ONE_BYTE, OPC_REMEMBER_STATE));
    directed_rows.push_back(row(MODE_RESTORE_STATE, 16'h0, 16'h0, '0, '0, '0,
                                CHK_ONE_BYTE, OPC_RESTORE_STATE));
    directed_rows.push_back(row(MODE_FIRST_UNUSED, 16'hFFFF, 16'hFFFF, '1, '1, '1,
                                CHK_NONE, '0));
    directed_rows.push_back(row(MODE_LAST_UNUSED, 16'h0, 16'h0, '0, '0, '0, CHK_NONE, '0));

    // Hold reset, then release it on a rising edge.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_instr(directed_rows[i].item);
      case (directed_rows[i].check)
        CHK_MODEL:    encode_instr(directed_rows[i].item);
        CHK_ONE_BYTE: expected_bytes.push_back('{out_byte: directed_rows[i].one_byte,
                                                 last_byte: 1'b1});
        default: ;  // dropped beat, nothing to expect
      endcase
    end

    // Random part. Unused modes are dropped by the block and do not count.
    random_sent = 0;
    while (random_sent < RANDOM_INSTRS) begin
      // Run a long stretch with no idling on either side.
      steady_flow <= (random_sent >= 200 && random_sent < 300);
      it = rand_instr();
      send_instr(it);
      encode_instr(it);
      if (it.mode <= MODE_RESTORE_STATE) random_sent++;
      // Once, drop valid and let the encoder drain completely before going on.
      if (random_sent == 120 && it.mode <= MODE_RESTORE_STATE) begin
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    steady_flow <= 1'b0;

    // Drain what is still pending, then keep watching for stray bytes.
    while (expected_bytes.size() != 0) @(posedge clk);
    for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clk);

    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never arrived", expected_bytes.size()));

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/cfa_enc_pkg.sv
hw/rtl/cfa_enc_ctrl.sv
hw/rtl/cfa_enc_dp.sv
hw/rtl/cfa_instruction_encoder.sv
hw/rtl/cfa_enc_chk.sv
verif/tb_cfa_instruction_encoder.sv
